/* hw/rtl/proximity_steering_pulse_drive_defines.svh */
// ----------------------------------------------------------------------------
// proximity steering pulse drive: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_STEERING_PULSE_DRIVE_DEFINES_SVH
`define PROXIMITY_STEERING_PULSE_DRIVE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSP_ASSERT_IMPL(label, ante, cons, msg)
`define PSP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/psp_pkg.sv */
// ----------------------------------------------------------------------------
// psp_pkg
// types and constants of the proximity steering pulse drive
// ----------------------------------------------------------------------------
package psp_pkg;

    localparam int SENSOR_BITS = 10;
    localparam int PEAK_W      = SENSOR_BITS + 1;
    localparam int SCALE_SHIFT = 6;
    localparam int DECAY_SHIFT = 6;
    localparam int DIV_W       = SENSOR_BITS + SCALE_SHIFT;
    localparam int TICK_W      = 7;
    localparam int MAG_W       = 7;
    localparam int NEAR_W      = 11;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int DRIVE_W     = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 3'd4;

    // register reset values
    localparam logic [TICK_W-1:0] ON_TICKS_RST   = 7'd4;
    localparam logic [TICK_W-1:0] OFF_TICKS_RST  = 7'd6;
    localparam logic [MAG_W-1:0]  PULSE_MAG_RST  = 7'd101;
    localparam logic [MAG_W-1:0]  DEAD_ZONE_RST  = 7'd8;
    localparam logic [NEAR_W-1:0] NEAR_LIMIT_RST = 11'd220;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd127;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd127;

    typedef struct packed {
        logic [SENSOR_BITS-1:0]      prox_left;
        logic [SENSOR_BITS-1:0]      prox_right;
        logic signed [DRIVE_W-1:0]   forward_cmd;
    } in_beat_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]   motor_left;
        logic signed [DRIVE_W-1:0]   motor_right;
    } out_beat_t;

    // saturate a 9-bit drive sum to +-127
    function automatic logic signed [DRIVE_W-1:0] clamp_drive(
        input logic signed [DRIVE_W:0] v
    );
        logic signed [DRIVE_W-1:0] r;
        if (v > DRIVE_W'(DRIVE_MAX) && v > 9'sd127) begin
            r = DRIVE_MAX;
        end
        else if (v < -9'sd127) begin
            r = DRIVE_MIN;
        end
        else begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/proximity_steering_pulse_drive.sv */
// ----------------------------------------------------------------------------
// proximity_steering_pulse_drive
// peak-normalized left/right steering with a pulsed turn and motor clamping
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_stall / in_data) takes one beat per control tick:
//   both proximity readings and a signed forward command. out channel
//   (out_valid / out_stall / out_data) returns one beat with both motor drives.
//   cfg_we / cfg_index / cfg_data write the five registers; the user must
//   do so only while idle (unchecked); an index past the last one is ignored.
// timing
//   the scaled difference comes from a restoring divider that retires one
//   quotient bit per cycle over DIV_W (16) bits; the finish state then puts
//   out_valid up once the output register is free, and in_stall drops with
//   it, so no new beat is taken before the last one is finished. with a
//   zero peak the divider is skipped and the beat goes to the finish state.
// reset
//   registers return to their defaults, the peak and pulse timer clear, the
//   pulse starts off so the first tick turns it on.
// stall
//   the result sits in the output register while out_stall is high; the next
//   beat is still taken and worked on, and waits in the finish state if the
//   output register is still full.
// ----------------------------------------------------------------------------
`include "proximity_steering_pulse_drive_defines.svh"

module proximity_steering_pulse_drive (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  psp_pkg::in_beat_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output psp_pkg::out_beat_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int PEAK_W = psp_pkg::PEAK_W;
    localparam int DIV_W  = psp_pkg::DIV_W;
    localparam int SB     = psp_pkg::SENSOR_BITS;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int CMP_W  = (PEAK_W > psp_pkg::NEAR_W) ? PEAK_W : psp_pkg::NEAR_W;
    localparam int DW     = psp_pkg::DRIVE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } state_t;

    // configuration registers
    logic [psp_pkg::TICK_W-1:0] on_ticks_reg;
    logic [psp_pkg::TICK_W-1:0] off_ticks_reg;
    logic [psp_pkg::MAG_W-1:0]  pulse_mag_reg;
    logic [psp_pkg::MAG_W-1:0]  dead_zone_reg;
    logic [psp_pkg::NEAR_W-1:0] near_limit_reg;

    // tracked state
    state_t                     state_reg, state_next;
    logic [PEAK_W-1:0]          peak_reg, peak_next;
    logic [psp_pkg::TICK_W-1:0] timer_reg, timer_next;
    logic                       pulse_on_reg, pulse_on_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    psp_pkg::out_beat_t         out_data_reg, out_data_next;

    // divider datapath (no reset)
    logic [DIV_W-1:0]           quo_reg, quo_next;
    logic [PEAK_W-1:0]          rem_reg, rem_next;
    logic                       neg_reg, neg_next;
    logic signed [DW-1:0]       fwd_reg, fwd_next;

    logic                       in_fire;
    logic [PEAK_W-1:0]          sum;
    logic [PEAK_W+psp_pkg::DECAY_SHIFT-1:0] decay_full;
    logic [PEAK_W-1:0]          new_peak;
    logic [SB-1:0]              abs_diff;
    logic                       diff_neg;
    logic [PEAK_W:0]            trial;
    logic                       trial_ge;
    logic                       turn_en;
    logic                       fwd_zero;
    logic signed [DW-1:0]       fwd_eff;
    logic signed [DW-1:0]       turn;
    logic signed [DW:0]         left_sum;
    logic signed [DW:0]         right_sum;
    logic                       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // peak tracker: jump up to a larger sum, else decay by 63/64
    assign sum        = PEAK_W'(in_data.prox_left) + PEAK_W'(in_data.prox_right);
    assign decay_full = {peak_reg, {psp_pkg::DECAY_SHIFT{1'b0}}}
                        - (PEAK_W + psp_pkg::DECAY_SHIFT)'(peak_reg);
    assign new_peak   = (sum > peak_reg) ? sum
                        : decay_full[PEAK_W+psp_pkg::DECAY_SHIFT-1:psp_pkg::DECAY_SHIFT];

    assign diff_neg = in_data.prox_right > in_data.prox_left;
    assign abs_diff = diff_neg ? (in_data.prox_right - in_data.prox_left)
                               : (in_data.prox_left - in_data.prox_right);

    // one restoring divide step
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, peak_reg};

    // result assembly from the finished quotient magnitude
    assign turn_en  = pulse_on_reg && (quo_reg != '0)
                      && (quo_reg >= DIV_W'(dead_zone_reg));
    assign fwd_zero = CMP_W'(peak_reg) > CMP_W'(near_limit_reg);
    assign fwd_eff  = fwd_zero ? '0 : fwd_reg;
    assign turn     = !turn_en ? '0
                      : (neg_reg ? -$signed({1'b0, pulse_mag_reg})
                                 :  $signed({1'b0, pulse_mag_reg}));
    assign left_sum  = (DW+1)'(fwd_eff) - (DW+1)'(turn);
    assign right_sum = (DW+1)'(fwd_eff) + (DW+1)'(turn);

    always_comb
    begin
        state_next     = state_reg;
        peak_next      = peak_reg;
        timer_next     = timer_reg;
        pulse_on_next  = pulse_on_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        fwd_next       = fwd_reg;

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire) begin
                    peak_next = new_peak;
                    neg_next  = diff_neg;
                    fwd_next  = in_data.forward_cmd;
                    rem_next  = '0;
                    cnt_next  = CNT_W'(DIV_W - 1);
                    // free-running pulse timer, a length of zero acts as one
                    if (timer_reg <= psp_pkg::TICK_W'(1)) begin
                        pulse_on_next = !pulse_on_reg;
                        timer_next    = pulse_on_reg ? off_ticks_reg : on_ticks_reg;
                    end
                    else begin
                        timer_next = timer_reg - 1'b1;
                    end
                    if (new_peak == '0) begin
                        // raw difference, no scaling
                        quo_next   = DIV_W'(abs_diff);
                        state_next = S_DONE;
                    end
                    else begin
                        quo_next   = {abs_diff, {psp_pkg::SCALE_SHIFT{1'b0}}};
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                quo_next = {quo_reg[DIV_W-2:0], trial_ge};
                rem_next = trial_ge ? PEAK_W'(trial - {1'b0, peak_reg})
                                    : trial[PEAK_W-1:0];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_data_next.motor_left  = psp_pkg::clamp_drive(left_sum);
                    out_data_next.motor_right = psp_pkg::clamp_drive(right_sum);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, tracked state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            peak_reg      <= '0;
            timer_reg     <= '0;
            pulse_on_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            timer_reg     <= timer_next;
            pulse_on_reg  <= pulse_on_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // divider operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        fwd_reg <= fwd_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            on_ticks_reg   <= psp_pkg::ON_TICKS_RST;
            off_ticks_reg  <= psp_pkg::OFF_TICKS_RST;
            pulse_mag_reg  <= psp_pkg::PULSE_MAG_RST;
            dead_zone_reg  <= psp_pkg::DEAD_ZONE_RST;
            near_limit_reg <= psp_pkg::NEAR_LIMIT_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                psp_pkg::REG_ON_TICKS:   on_ticks_reg   <= cfg_data[psp_pkg::TICK_W-1:0];
                psp_pkg::REG_OFF_TICKS:  off_ticks_reg  <= cfg_data[psp_pkg::TICK_W-1:0];
                psp_pkg::REG_PULSE_MAG:  pulse_mag_reg  <= cfg_data[psp_pkg::MAG_W-1:0];
                psp_pkg::REG_DEAD_ZONE:  dead_zone_reg  <= cfg_data[psp_pkg::MAG_W-1:0];
                psp_pkg::REG_NEAR_LIMIT: near_limit_reg <= cfg_data[psp_pkg::NEAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // an accepted beat always starts work
    `PSP_ASSERT_NEXT(a_accept_busy, in_fire, state_reg != S_IDLE, "accept left block idle")
    // partial remainder stays below the divisor
    `PSP_ASSERT_IMPL(a_rem_bound, state_reg == S_DIV, rem_reg < peak_reg, "remainder overflow")
    // a divide never starts with a zero peak
    `PSP_ASSERT_IMPL(a_div_nonzero, state_reg == S_DIV, peak_reg != '0, "divide by zero peak")
    // clamping never lets the most negative code through
    `PSP_ASSERT_IMPL(a_clamp, out_valid_reg,
        out_data_reg.motor_left != 8'sh80 && out_data_reg.motor_right != 8'sh80,
        "motor drive not clamped")

endmodule

/* tb/proximity_steering_pulse_drive_test.sv */
// ----------------------------------------------------------------------------
// proximity_steering_pulse_drive_test
// self-checking bench: beats go in through a gap-inserting driver, a local
// steering predictor computes both motor drives for each accepted beat, and a
// stalling monitor compares every returned beat against the oldest prediction
// ----------------------------------------------------------------------------
module proximity_steering_pulse_drive_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_IDX_W   = psp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = psp_pkg::CFG_DATA_W;
    localparam int TICK_W      = psp_pkg::TICK_W;
    localparam int MAG_W       = psp_pkg::MAG_W;
    localparam int NEAR_W      = psp_pkg::NEAR_W;
    localparam int PEAK_W      = psp_pkg::PEAK_W;
    localparam int DRIVE_W     = psp_pkg::DRIVE_W;
    localparam int SENSOR_BITS = psp_pkg::SENSOR_BITS;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = psp_pkg::REG_NEAR_LIMIT + 3'd1;
    // idle cycles after the last result before a register write or the verdict
    localparam int SETTLE_CYCLES = 24;
    // random ticks per register setting
    localparam int PHASE_TICKS = 113;
    localparam int PHASES = 6;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    psp_pkg::in_beat_t      in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    psp_pkg::out_beat_t     out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    proximity_steering_pulse_drive uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // steering predictor: own copy of the registers and the tick state
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]      on_len;
    logic [TICK_W-1:0]      off_len;
    logic [MAG_W-1:0]       turn_mag;
    logic [MAG_W-1:0]       dead_band;
    logic [NEAR_W-1:0]      near_max;
    logic [PEAK_W-1:0]      peak_track;
    logic [7:0]             pulse_count;
    logic                   pulse_live;

    psp_pkg::in_beat_t      tick_queue[$];     // beats waiting for the driver
    psp_pkg::out_beat_t     drive_expect[$];   // predicted motor beats, oldest first
    int                     mismatches = 0;
    bit                     calm = 1'b0;       // no idling on either side while set

    function automatic int saturate(input int v);
        if (v > 127)
            return 127;
        if (v < -127)
            return -127;
        return v;
    endfunction

    // one control tick: advances peak and pulse state, returns both drives
    function automatic psp_pkg::out_beat_t steer_step(input psp_pkg::in_beat_t beat);
        int                 sum_now;
        int                 diff;
        int                 fwd;
        int                 turn;
        int                 mag;
        psp_pkg::out_beat_t drive;
        sum_now = int'(beat.prox_left) + int'(beat.prox_right);
        // jump up to a larger sum, otherwise decay by 63/64
        if (sum_now > int'(peak_track))
            peak_track = PEAK_W'(sum_now);
        else
            peak_track = PEAK_W'((int'(peak_track) * ((1 << psp_pkg::DECAY_SHIFT) - 1))
                                 >> psp_pkg::DECAY_SHIFT);
        // normalized difference, raw when the peak is zero
        diff = int'(beat.prox_left) - int'(beat.prox_right);
        if (peak_track != '0)
            diff = (diff * (1 << psp_pkg::SCALE_SHIFT)) / int'(peak_track);
        fwd = int'(beat.forward_cmd);
        if (peak_track > near_max)
            fwd = 0;
        mag = (diff < 0) ? -diff : diff;
        if (mag < int'(dead_band))
            diff = 0;
        // free-running pulse, a length of zero behaves as one
        if (pulse_count <= 8'd1)
        begin
            pulse_live = ~pulse_live;
            pulse_count = pulse_live ? {1'b0, on_len} : {1'b0, off_len};
        end
        else
        begin
            pulse_count = pulse_count - 8'd1;
        end
        turn = 0;
        if (pulse_live && diff > 0)
            turn = int'(turn_mag);
        else if (pulse_live && diff < 0)
            turn = -int'(turn_mag);
        drive.motor_left = DRIVE_W'(saturate(fwd - turn));
        drive.motor_right = DRIVE_W'(saturate(fwd + turn));
        return drive;
    endfunction

    // idle length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // ------------------------------------------------------------------
    // driver: holds a beat until taken, then may idle before the next one
    // ------------------------------------------------------------------
    int send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            // accepted beat: predict its drives now, in order
            if (in_valid && !in_stall)
                drive_expect.push_back(steer_step(in_data));
            // channel free after this edge
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    in_data <= tick_queue.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random stall, checks each taken beat field by field
    // ------------------------------------------------------------------
    int hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        psp_pkg::out_beat_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_expect.size() == 0)
                begin
                    $display("%0t unexpected beat: expected none, got left %0d right %0d",
                             $time, out_data.motor_left, out_data.motor_right);
                    mismatches++;
                end
                else
                begin
                    want = drive_expect.pop_front();
                    if (out_data.motor_left !== want.motor_left)
                    begin
                        $display("%0t motor_left: expected %0d, got %0d",
                                 $time, want.motor_left, out_data.motor_left);
                        mismatches++;
                    end
                    if (out_data.motor_right !== want.motor_right)
                    begin
                        $display("%0t motor_right: expected %0d, got %0d",
                                 $time, want.motor_right, out_data.motor_right);
                        mismatches++;
                    end
                end
            end
            // stalls come in runs, and out_stall drops between any two runs
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                hold_left <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input int left, input int right, input int fwd);
        psp_pkg::in_beat_t beat;
        beat.prox_left = SENSOR_BITS'(left);
        beat.prox_right = SENSOR_BITS'(right);
        beat.forward_cmd = DRIVE_W'(fwd);
        tick_queue.push_back(beat);
    endtask

    // register write, mirrored into the predictor; out-of-range index dropped
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            psp_pkg::REG_ON_TICKS:   on_len = value[TICK_W-1:0];
            psp_pkg::REG_OFF_TICKS:  off_len = value[TICK_W-1:0];
            psp_pkg::REG_PULSE_MAG:  turn_mag = value[MAG_W-1:0];
            psp_pkg::REG_DEAD_ZONE:  dead_band = value[MAG_W-1:0];
            psp_pkg::REG_NEAR_LIMIT: near_max = value[NEAR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every predicted beat is back and the block has gone quiet;
    // sampled mid-cycle so the edge's own updates are already visible
    task automatic settle();
        while (tick_queue.size() != 0 || in_valid || drive_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register value: extremes often, junk above the field width now and then
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int width);
        logic [CFG_DATA_W-1:0] value;
        int                    roll;
        roll = $urandom_range(3);
        if (roll == 0)
            value = '0;
        else if (roll == 1)
            value = CFG_DATA_W'((1 << width) - 1);
        else
            value = CFG_DATA_W'($urandom_range((1 << width) - 1));
        if (width < CFG_DATA_W && $urandom_range(6) == 0)
            value = value | (CFG_DATA_W'($urandom) << width);
        return value;
    endfunction

    // forward command with the extremes and zero weighted up
    function automatic int pick_fwd();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return -128;
        if (roll == 1)
            return 127;
        if (roll == 2)
            return 0;
        return $signed(8'($urandom));
    endfunction

    // one burst of readings around a level, or a quiet run that lets the peak decay
    task automatic push_burst(output int pushed);
        int level;
        int len;
        int base;
        int other;
        int k;
        calm = ($urandom_range(4) == 0);
        if ($urandom_range(6) == 0)
        begin
            len = $urandom_range(160, 10);
            for (k = 0; k < len; k++)
                push_tick(0, 0, pick_fwd());
            pushed = len;
            return;
        end
        case ($urandom_range(3))
            0: level = 15;
            1: level = 63;
            2: level = 255;
            default: level = (1 << SENSOR_BITS) - 1;
        endcase
        len = $urandom_range(40, 5);
        for (k = 0; k < len; k++)
        begin
            base = $urandom_range(level);
            // near-equal readings probe the dead zone
            if ($urandom_range(9) < 3)
                other = base + $urandom_range(8) - 4;
            else
                other = $urandom_range(level);
            if (other < 0)
                other = 0;
            if (other > (1 << SENSOR_BITS) - 1)
                other = (1 << SENSOR_BITS) - 1;
            if ($urandom_range(1))
                push_tick(base, other, pick_fwd());
            else
                push_tick(other, base, pick_fwd());
        end
        pushed = len;
    endtask

    // ------------------------------------------------------------------
    // sequence: reset, directed ticks, then random phases between writes
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int count;
        int pushed;
        on_len = psp_pkg::ON_TICKS_RST;
        off_len = psp_pkg::OFF_TICKS_RST;
        turn_mag = psp_pkg::PULSE_MAG_RST;
        dead_band = psp_pkg::DEAD_ZONE_RST;
        near_max = psp_pkg::NEAR_LIMIT_RST;
        peak_track = '0;
        pulse_count = '0;
        pulse_live = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero peak, full-scale readings, forward extremes
        push_tick(0, 0, 0);
        push_tick(0, 0, -128);
        push_tick(0, 0, 127);
        push_tick(1023, 0, 127);
        push_tick(0, 1023, -128);
        push_tick(1023, 1023, 0);
        // sum at or under the peak: the peak decays and the scaled value stays below 64
        push_tick(1023, 0, -1);
        push_tick(1023, 0, 1);
        push_tick(512, 0, 50);
        push_tick(1, 0, 64);
        push_tick(0, 2, -64);
        push_tick(300, 300, 100);
        push_tick(0, 0, -128);
        push_tick(700, 0, -128);
        settle();

        // zero pulse lengths, full turn, no dead zone, forward always cut
        write_reg(psp_pkg::REG_ON_TICKS, '0);
        write_reg(psp_pkg::REG_OFF_TICKS, '0);
        write_reg(psp_pkg::REG_PULSE_MAG, CFG_DATA_W'(127));
        write_reg(psp_pkg::REG_DEAD_ZONE, '0);
        write_reg(psp_pkg::REG_NEAR_LIMIT, '0);
        write_reg(REG_SPARE, '1);
        push_tick(5, 5, 127);
        push_tick(6, 5, -128);
        push_tick(5, 6, 127);
        push_tick(1023, 0, -128);
        push_tick(0, 1023, 127);
        push_tick(1, 0, 0);
        push_tick(0, 1, 0);
        push_tick(1023, 1023, -1);
        settle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                // every register at its top value, forward never cut
                write_reg(psp_pkg::REG_ON_TICKS, CFG_DATA_W'(127));
                write_reg(psp_pkg::REG_OFF_TICKS, CFG_DATA_W'(127));
                write_reg(psp_pkg::REG_PULSE_MAG, CFG_DATA_W'(127));
                write_reg(psp_pkg::REG_DEAD_ZONE, CFG_DATA_W'(127));
                write_reg(psp_pkg::REG_NEAR_LIMIT, CFG_DATA_W'(2047));
            end
            else
            begin
                write_reg(psp_pkg::REG_ON_TICKS, pick_setting(TICK_W));
                write_reg(psp_pkg::REG_OFF_TICKS, pick_setting(TICK_W));
                write_reg(psp_pkg::REG_PULSE_MAG, pick_setting(MAG_W));
                write_reg(psp_pkg::REG_DEAD_ZONE, pick_setting(MAG_W));
                write_reg(psp_pkg::REG_NEAR_LIMIT, pick_setting(NEAR_W));
                if ($urandom_range(2) == 0)
                    write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(2)),
                              CFG_DATA_W'($urandom));
            end
            count = 0;
            while (count < PHASE_TICKS)
            begin
                push_burst(pushed);
                count += pushed;
            end
            settle();
            calm = 1'b0;
        end

        if (mismatches == 0)
            $display("PASS proximity_steering_pulse_drive");
        else
            $display("FAIL proximity_steering_pulse_drive");
        $finish;
    end

    // run limit, far past the slowest correct run
    initial
    begin
        #8_000_000;
        $display("FAIL proximity_steering_pulse_drive");
        $finish;
    end

endmodule

/* proximity_steering_pulse_drive.f */
+incdir+hw/rtl
hw/rtl/psp_pkg.sv
hw/rtl/proximity_steering_pulse_drive.sv
tb/proximity_steering_pulse_drive_test.sv
